// ===== src/mbf_pkg.sv =====
`default_nettype none
package mbf_pkg;

  localparam int unsigned MantW     = 56;
  localparam int unsigned ExpW      = 12;
  localparam int unsigned CntW      = 6;
  localparam int unsigned NumCells  = 154;
  localparam int unsigned HiddenPos = 55;
  localparam int unsigned AddOvfPos = 59;
  localparam int unsigned SeedSteps = 25;

  localparam logic [ExpW-1:0] MulBias   = 12'd184;
  localparam logic [ExpW-1:0] DivBias   = 12'd129;
  localparam logic [ExpW-1:0] FloorBase = 12'd184;
  localparam logic [ExpW-1:0] FloorMin  = 12'd128;
  localparam logic [ExpW-1:0] SeedBias  = 12'h040;
  localparam logic [31:0]     SeedMask  = 32'h007f_ffff;

  localparam logic [CntW-1:0] NormLast = 6'd5;
  localparam logic [CntW-1:0] SeedLast = CntW'(SeedSteps - 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(MantW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(HiddenPos - 1);

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_MUL   = 3'd1;
  localparam logic [2:0] MODE_DIV   = 3'd2;
  localparam logic [2:0] MODE_SQRT  = 3'd3;
  localparam logic [2:0] MODE_FLOOR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EXP   = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_FLOOR = 2'd3;

  localparam logic [3:0] PH_DONE  = 4'd0;
  localparam logic [3:0] PH_FLOOR = 4'd1;
  localparam logic [3:0] PH_ADD0  = 4'd2;
  localparam logic [3:0] PH_ADD1  = 4'd3;
  localparam logic [3:0] PH_ADD2  = 4'd4;
  localparam logic [3:0] PH_MUL   = 4'd5;
  localparam logic [3:0] PH_MRND  = 4'd6;
  localparam logic [3:0] PH_NORM  = 4'd7;
  localparam logic [3:0] PH_DIV0  = 4'd8;
  localparam logic [3:0] PH_DIVS  = 4'd9;
  localparam logic [3:0] PH_DIVG  = 4'd10;
  localparam logic [3:0] PH_DIVR  = 4'd11;
  localparam logic [3:0] PH_SEED  = 4'd12;
  localparam logic [3:0] PH_SFIN  = 4'd13;

  typedef struct packed {
    logic [2:0]       mode;
    logic [3:0]       ph;
    logic [CntW-1:0]  cnt;
    logic             zr;
    logic             it;
    logic             grd;
    logic [MantW-1:0] am;
    logic [ExpW-1:0]  ae;
    logic [MantW-1:0] bm;
    logic [ExpW-1:0]  be;
    logic [MantW-1:0] rm;
    logic [ExpW-1:0]  re;
    logic [59:0]      rem;
    logic [MantW-1:0] q;
    logic [63:0]      ival;
    logic [1:0]       st;
  } rec_t;

endpackage
`default_nettype wire

// ===== src/mbf_in_if.sv =====
`default_nettype none
interface mbf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [55:0] a_mantissa;
  logic [7:0]  a_exponent;
  logic [55:0] b_mantissa;
  logic [7:0]  b_exponent;

  modport source (
    output valid, mode, a_mantissa, a_exponent, b_mantissa, b_exponent,
    input  ready
  );
  modport sink (
    input  valid, mode, a_mantissa, a_exponent, b_mantissa, b_exponent,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/mbf_out_if.sv =====
`default_nettype none
interface mbf_out_if;
  logic        valid;
  logic        ready;
  logic [55:0] result_mantissa;
  logic [7:0]  result_exponent;
  logic [63:0] int_result;
  logic [1:0]  status;

  modport source (
    output valid, result_mantissa, result_exponent, int_result, status,
    input  ready
  );
  modport sink (
    input  valid, result_mantissa, result_exponent, int_result, status,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/mbf_cell.sv =====
`default_nettype none
module mbf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  mbf_pkg::rec_t rec_i,
  output logic          vld_o,
  output mbf_pkg::rec_t rec_o
);

  function automatic logic [59:0] shr_stk(input logic [59:0] v, input logic [11:0] s);
    logic [59:0] msk;
    logic [59:0] res;
    msk = ~({60{1'b1}} << s[5:0]);
    if (s >= 12'd60) begin
      res = {59'd0, |v};
    end else begin
      res = (v >> s[5:0]) | {59'd0, |(v & msk)};
    end
    return res;
  endfunction

  logic          vld_q;
  mbf_pkg::rec_t rec_q;
  mbf_pkg::rec_t rec_d;
  logic          is_sqrt;

  logic [55:0] px_m, py_m, x_m, y_m;
  logic [11:0] px_e, py_e, x_e, y_e, dsh;
  logic        swp;
  logic [59:0] ext_y, ext, ext_n;
  logic [55:0] aq, a_m;
  logic [2:0]  ag;
  logic        a_inc;
  logic [56:0] a_sum;
  logic [11:0] a_e;

  logic [56:0]  m_sum, m_rnd;
  logic [111:0] prod;
  logic         m_top, m_grd, m_stk, m_inc;
  logic [55:0]  mq;
  logic [11:0]  m_sh, m_e;

  logic [5:0] nk;
  logic       a_top0, b_top0;

  logic        d_adj, d_ge, d_inc;
  logic [56:0] d_num, d_first, d_rnd;
  logic [57:0] d_t, d_sub;

  logic [31:0] s_rem, s_rt, s_root, s_remn, s_fin, s_msk;
  logic [15:0] s_low;
  logic        s_lt;

  logic        f_big, f_ovf;
  logic [11:0] f_up, f_dn;
  logic [63:0] f_wide, f_val;

  assign is_sqrt = (rec_i.mode == mbf_pkg::MODE_SQRT);

  assign px_m  = is_sqrt ? rec_i.bm : rec_i.am;
  assign px_e  = is_sqrt ? rec_i.be : rec_i.ae;
  assign py_m  = is_sqrt ? rec_i.rm : rec_i.bm;
  assign py_e  = is_sqrt ? rec_i.re : rec_i.be;
  assign swp   = $signed(py_e) > $signed(px_e);
  assign x_m   = swp ? py_m : px_m;
  assign x_e   = swp ? py_e : px_e;
  assign y_m   = swp ? px_m : py_m;
  assign y_e   = swp ? px_e : py_e;
  assign dsh   = x_e - y_e;
  assign ext_y = shr_stk({1'b0, y_m, 3'b000}, dsh);

  assign ext   = {1'b0, rec_i.rm, 3'b000} + rec_i.rem;
  assign ext_n = ext[59] ? ({1'b0, ext[59:1]} | {59'd0, ext[0]}) : ext;

  assign aq    = rec_i.rem[58:3];
  assign ag    = rec_i.rem[2:0];
  assign a_inc = (ag > 3'd4) || ((ag == 3'd4) && aq[0]);
  assign a_sum = {1'b0, aq} + {56'd0, a_inc};
  assign a_m   = a_sum[56] ? a_sum[56:1] : a_sum[55:0];
  assign a_e   = rec_i.re + {11'd0, a_sum[56]};

  assign m_sum = {1'b0, rec_i.rem[55:0]} + (rec_i.bm[0] ? {1'b0, rec_i.am} : 57'd0);
  assign prod  = {rec_i.rem[55:0], rec_i.q};
  assign m_top = prod[111];
  assign mq    = m_top ? prod[111:56] : prod[110:55];
  assign m_grd = m_top ? prod[55] : prod[54];
  assign m_stk = m_top ? (|prod[54:0]) : (|prod[53:0]);
  assign m_inc = m_grd && (m_stk || mq[0]);
  assign m_rnd = {1'b0, mq} + {56'd0, m_inc};
  assign m_sh  = m_top ? 12'd56 : 12'd55;
  assign m_e   = rec_i.ae + rec_i.be + m_sh - mbf_pkg::MulBias + {11'd0, m_rnd[56]};

  assign nk     = 6'd32 >> rec_i.cnt[2:0];
  assign a_top0 = (rec_i.am >> (6'd56 - nk)) == 56'd0;
  assign b_top0 = (rec_i.bm >> (6'd56 - nk)) == 56'd0;

  assign d_adj   = rec_i.am < rec_i.bm;
  assign d_num   = d_adj ? {rec_i.am, 1'b0} : {1'b0, rec_i.am};
  assign d_first = d_num - {1'b0, rec_i.bm};
  assign d_t     = {rec_i.rem[56:0], 1'b0};
  assign d_ge    = d_t >= {2'b00, rec_i.bm};
  assign d_sub   = d_ge ? (d_t - {2'b00, rec_i.bm}) : d_t;
  assign d_inc   = rec_i.grd && ((rec_i.rem != 60'd0) || rec_i.q[0]);
  assign d_rnd   = {1'b0, rec_i.q} + {56'd0, d_inc};

  assign s_rem  = {rec_i.rem[29:0], rec_i.ival[31:30]};
  assign s_rt   = {rec_i.q[30:0], 1'b1};
  assign s_lt   = s_rem < s_rt;
  assign s_low  = s_lt ? (s_rt[15:0] - 16'd1) : (s_rt[15:0] + 16'd1);
  assign s_root = {s_rt[31:16], s_low};
  assign s_remn = s_lt ? s_rem : (s_rem - s_rt);
  assign s_fin  = {2'b00, rec_i.q[31:2]} + {31'd0, rec_i.q[1]};
  assign s_msk  = s_fin & mbf_pkg::SeedMask;

  assign f_big  = rec_i.ae >= mbf_pkg::FloorBase;
  assign f_up   = rec_i.ae - mbf_pkg::FloorBase;
  assign f_dn   = mbf_pkg::FloorBase - rec_i.ae;
  assign f_wide = {8'd0, rec_i.am};
  assign f_ovf  = (f_up[6:0] >= 7'd64) ||
                  ((f_up[6:0] != 7'd0) && ((f_wide >> (7'd64 - f_up[6:0])) != 64'd0));

  always_comb begin
    if ((rec_i.am == 56'd0) || (rec_i.ae <= mbf_pkg::FloorMin)) begin
      f_val = 64'd0;
    end else if (f_big) begin
      f_val = f_ovf ? {64{1'b1}} : (f_wide << f_up[5:0]);
    end else begin
      f_val = f_wide >> f_dn[5:0];
    end
  end

  always_comb begin
    rec_d = rec_i;
    unique case (rec_i.ph)
      mbf_pkg::PH_ADD0: begin
        if (px_m == 56'd0) begin
          rec_d.rm = py_m;
          rec_d.re = py_e;
          rec_d.ph = mbf_pkg::PH_DONE;
        end else if (py_m == 56'd0) begin
          rec_d.rm = px_m;
          rec_d.re = px_e;
          rec_d.ph = mbf_pkg::PH_DONE;
        end else begin
          rec_d.rm  = x_m;
          rec_d.re  = x_e;
          rec_d.rem = ext_y;
          rec_d.ph  = mbf_pkg::PH_ADD1;
        end
      end
      mbf_pkg::PH_ADD1: begin
        rec_d.rem = ext_n;
        rec_d.re  = rec_i.re + {11'd0, ext[59]};
        rec_d.ph  = mbf_pkg::PH_ADD2;
      end
      mbf_pkg::PH_ADD2: begin
        if (is_sqrt) begin
          rec_d.bm = a_m;
          rec_d.be = a_e - 12'd1;
          if (rec_i.it) begin
            rec_d.rm = a_m;
            rec_d.re = a_e - 12'd1;
            rec_d.ph = mbf_pkg::PH_DONE;
          end else begin
            rec_d.it = 1'b1;
            rec_d.ph = mbf_pkg::PH_DIV0;
          end
        end else begin
          rec_d.rm = a_m;
          rec_d.re = a_e;
          rec_d.ph = mbf_pkg::PH_DONE;
        end
      end
      mbf_pkg::PH_MUL: begin
        rec_d.rem = {4'd0, m_sum[56:1]};
        rec_d.q   = {m_sum[0], rec_i.q[55:1]};
        rec_d.bm  = {1'b0, rec_i.bm[55:1]};
        if (rec_i.cnt == mbf_pkg::MulLast) begin
          rec_d.cnt = '0;
          rec_d.ph  = mbf_pkg::PH_MRND;
        end else begin
          rec_d.cnt = rec_i.cnt + 6'd1;
        end
      end
      mbf_pkg::PH_MRND: begin
        rec_d.rm = m_rnd[56] ? m_rnd[56:1] : m_rnd[55:0];
        rec_d.re = m_e;
        rec_d.ph = mbf_pkg::PH_DONE;
      end
      mbf_pkg::PH_NORM: begin
        if (a_top0) begin
          rec_d.am = rec_i.am << nk;
          rec_d.ae = rec_i.ae - {6'd0, nk};
        end
        if (b_top0) begin
          rec_d.bm = rec_i.bm << nk;
          rec_d.be = rec_i.be - {6'd0, nk};
        end
        if (rec_i.cnt == mbf_pkg::NormLast) begin
          rec_d.cnt = '0;
          rec_d.ph  = is_sqrt ? mbf_pkg::PH_SEED : mbf_pkg::PH_DIV0;
        end else begin
          rec_d.cnt = rec_i.cnt + 6'd1;
        end
      end
      mbf_pkg::PH_DIV0: begin
        rec_d.rem = {3'd0, d_first};
        rec_d.q   = 56'd1;
        rec_d.re  = mbf_pkg::DivBias + rec_i.ae - rec_i.be - {11'd0, d_adj};
        rec_d.cnt = '0;
        rec_d.ph  = mbf_pkg::PH_DIVS;
      end
      mbf_pkg::PH_DIVS: begin
        rec_d.rem = {2'd0, d_sub};
        rec_d.q   = {rec_i.q[54:0], d_ge};
        if (rec_i.cnt == mbf_pkg::DivLast) begin
          rec_d.cnt = '0;
          rec_d.ph  = mbf_pkg::PH_DIVG;
        end else begin
          rec_d.cnt = rec_i.cnt + 6'd1;
        end
      end
      mbf_pkg::PH_DIVG: begin
        rec_d.rem = {2'd0, d_sub};
        rec_d.grd = d_ge;
        rec_d.ph  = mbf_pkg::PH_DIVR;
      end
      mbf_pkg::PH_DIVR: begin
        rec_d.rm = d_rnd[56] ? d_rnd[56:1] : d_rnd[55:0];
        rec_d.re = rec_i.re + {11'd0, d_rnd[56]};
        rec_d.ph = is_sqrt ? mbf_pkg::PH_ADD0 : mbf_pkg::PH_DONE;
      end
      mbf_pkg::PH_SEED: begin
        rec_d.rem  = {28'd0, s_remn};
        rec_d.q    = {24'd0, s_root};
        rec_d.ival = {32'd0, rec_i.ival[29:0], 2'b00};
        if (rec_i.cnt == mbf_pkg::SeedLast) begin
          rec_d.cnt = '0;
          rec_d.ph  = mbf_pkg::PH_SFIN;
        end else begin
          rec_d.cnt = rec_i.cnt + 6'd1;
        end
      end
      mbf_pkg::PH_SFIN: begin
        rec_d.bm = {1'b1, s_msk[22:0], 32'd0};
        rec_d.be = rec_i.re;
        rec_d.it = 1'b0;
        rec_d.ph = mbf_pkg::PH_DIV0;
      end
      mbf_pkg::PH_FLOOR: begin
        rec_d.ival = f_val;
        if ((rec_i.am != 56'd0) && (rec_i.ae > mbf_pkg::FloorMin) && f_big && f_ovf) begin
          rec_d.st = mbf_pkg::ST_FLOOR;
        end
        rec_d.ph = mbf_pkg::PH_DONE;
      end
      default: begin
        rec_d = rec_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_q <= rec_d;
    end
  end

  assign vld_o = vld_q;
  assign rec_o = rec_q;

endmodule
`default_nettype wire

// ===== src/mbf64_float_arith_unit.sv =====
// Throughput: one operation per cycle in every mode, one new transfer accepted each cycle
// while the output is not stalled.
// The length of the cell row is set by the square root: a 6-step normalize,
// 25 seed steps, one seed rounding step and two passes of a 58-step divide, each followed by
// a 3-step add.
// A stalled output freezes the whole row. Reset clears only the valid flags.
`default_nettype none
module mbf64_float_arith_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbf_in_if.sink    in_i,
  mbf_out_if.source out_o
);

  localparam int unsigned N = mbf_pkg::NumCells;

  logic          adv;
  logic [N:0]    vld;
  mbf_pkg::rec_t rec [0:N];
  mbf_pkg::rec_t init;
  mbf_pkg::rec_t lst;
  logic          odd;

  logic [55:0] fm;
  logic [7:0]  fe;
  logic [63:0] fi;
  logic [1:0]  fs;

  logic        out_vld_q;
  logic [55:0] mant_q;
  logic [7:0]  exp_q;
  logic [63:0] int_q;
  logic [1:0]  st_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;
  assign odd        = in_i.a_exponent[0];

  always_comb begin
    init      = '0;
    init.mode = in_i.mode;
    init.am   = in_i.a_mantissa;
    init.ae   = {4'd0, in_i.a_exponent};
    init.bm   = in_i.b_mantissa;
    init.be   = {4'd0, in_i.b_exponent};
    case (in_i.mode)
      mbf_pkg::MODE_ADD:   init.ph = mbf_pkg::PH_ADD0;
      mbf_pkg::MODE_MUL:   init.ph = mbf_pkg::PH_MUL;
      mbf_pkg::MODE_DIV: begin
        if (in_i.b_mantissa == 56'd0) begin
          init.st = mbf_pkg::ST_DIV0;
          init.zr = 1'b1;
          init.ph = mbf_pkg::PH_DONE;
        end else begin
          init.zr = (in_i.a_mantissa == 56'd0);
          init.ph = mbf_pkg::PH_NORM;
        end
      end
      mbf_pkg::MODE_SQRT: begin
        init.zr   = (in_i.a_mantissa == 56'd0);
        init.bm   = {1'b1, 55'd0};
        init.be   = '0;
        init.ival = {32'd0, ({in_i.a_mantissa[55:32], 8'd0} >> odd)};
        init.re   = {5'd0, in_i.a_exponent[7:1]} + mbf_pkg::SeedBias + {11'd0, odd};
        init.ph   = mbf_pkg::PH_NORM;
      end
      mbf_pkg::MODE_FLOOR: init.ph = mbf_pkg::PH_FLOOR;
      default:             init.ph = mbf_pkg::PH_DONE;
    endcase
  end

  assign vld[0] = in_i.valid;
  assign rec[0] = init;

  for (genvar g = 0; g < N; g++) begin : g_cell
    mbf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (vld[g]),
      .rec_i  (rec[g]),
      .vld_o  (vld[g+1]),
      .rec_o  (rec[g+1])
    );
  end

  assign lst = rec[N];

  always_comb begin
    fm = lst.zr ? 56'd0 : lst.rm;
    fs = lst.st;
    if ((lst.mode <= mbf_pkg::MODE_SQRT) && (fm != 56'd0) &&
        (($signed(lst.re) < 12'sd1) || ($signed(lst.re) > 12'sd255))) begin
      fs = mbf_pkg::ST_EXP;
    end
    fe = (fm == 56'd0) ? 8'd0 : lst.re[7:0];
    fi = (lst.mode == mbf_pkg::MODE_FLOOR) ? lst.ival : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mant_q <= fm;
      exp_q  <= fe;
      int_q  <= fi;
      st_q   <= fs;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.result_mantissa = mant_q;
  assign out_o.result_exponent = exp_q;
  assign out_o.int_result      = int_q;
  assign out_o.status          = st_q;

endmodule
`default_nettype wire

// ===== src/mbf_checker.sv =====
`default_nettype none
module mbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [55:0] mant_i,
  input logic [7:0]  exp_i,
  input logic [63:0] int_i,
  input logic [1:0]  status_i
);

  // A result that is not taken stays on the output unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mant_i) && $stable(exp_i) &&
      $stable(int_i) && $stable(status_i))
    else $error("stalled result changed");

  // The input side is held off only by a result that waits for its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (mant_i == 56'd0) |-> exp_i == 8'd0)
    else $error("zero result with nonzero exponent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == mbf_pkg::ST_DIV0) |-> mant_i == 56'd0 && int_i == 64'd0)
    else $error("divide by zero with nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (int_i != 64'd0) |->
      mant_i == 56'd0 && (status_i == mbf_pkg::ST_OK || status_i == mbf_pkg::ST_FLOOR))
    else $error("integer result outside floor");

endmodule

bind mbf64_float_arith_unit mbf_checker u_mbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .mant_i      (out_o.result_mantissa),
  .exp_i       (out_o.result_exponent),
  .int_i       (out_o.int_result),
  .status_i    (out_o.status)
);
`default_nettype wire
